/* rtl/periodic_timer_bank_top_defines.svh */
// assertion macros shared by the checker of the periodic timer bank
// no dependencies; included by bare file name
`ifndef PERIODIC_TIMER_BANK_TOP_DEFINES_SVH
`define PERIODIC_TIMER_BANK_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define PTB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ptb_pkg.sv */
// types, constants and codes of the periodic timer bank
// no dependencies
`timescale 1ns / 1ps

package ptb_pkg;

   localparam int MAX_TIMERS = 16;
   localparam int IDX_W      = $clog2(MAX_TIMERS);
   localparam int COUNT_W    = $clog2(MAX_TIMERS + 1);
   localparam int FIELD_W    = 21;
   localparam int PERIOD_W   = 20;
   localparam int SEC_W      = 32;
   localparam int DIVIDEND_W = SEC_W + 1;
   localparam int ENTRY_W    = PERIOD_W + SEC_W;

   typedef enum logic [2:0] {
      KIND_ADDED       = 3'd0,
      KIND_BAD_INTERVAL = 3'd1,
      KIND_FULL        = 3'd2,
      KIND_FIRED       = 3'd3,
      KIND_IDLE        = 3'd4
   } kind_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_ADD  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_CHECK,
      ST_ADD_PHASE,
      ST_ADD_FIRST,
      ST_TICK_EVAL,
      ST_TICK_END,
      ST_RESP
   } state_type;

endpackage

/* rtl/ptb_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ptb_rem.sv */
// serial restoring remainder unit, one dividend bit per cycle
// depends on ptb_pkg
`timescale 1ns / 1ps

module ptb_rem
   import ptb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [PERIOD_W-1:0]   divisor,
   output logic                  done,
   output logic [PERIOD_W-1:0]   remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] shift_ff, shift_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [PERIOD_W:0]     partial;

   always_comb begin
      partial  = {rem_ff, shift_ff[DIVIDEND_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = CNT_W'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         shift_in = {shift_ff[DIVIDEND_W-2:0], 1'b0};
         if (partial >= {1'b0, divisor}) begin
            rem_in = PERIOD_W'(partial - {1'b0, divisor});
         end else begin
            rem_in = partial[PERIOD_W-1:0];
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/periodic_timer_bank_top.sv */
// periodic timer bank: a table of periodic timers driven by a one-second tick
// depends on ptb_pkg, ptb_ram and ptb_rem
`timescale 1ns / 1ps

// the block keeps up to MAX_TIMERS periodic timers in one ram entry each
// (period and next due second) and a saturating seconds counter. an add
// transaction checks the interval and the table space, then runs the serial
// remainder unit twice (phase modulo interval, then current second plus one
// modulo interval) and writes the new entry. a tick transaction bumps the
// counter and walks the valid entries one per cycle through the ram (read
// one entry while writing back the previous one) unless a due entry has to
// wait for the result side. one input transaction is in work at a time;
// req_tready is high only between transactions. results go out through a
// single output register, so a finished result can wait on rsp_tready while
// the next request is already taken. a tick yields one fired result per due
// entry in index order, or one idle result; rsp_tlast marks the final one.
// no clearing pass: only entries below the fill count are ever read

module periodic_timer_bank_top
   import ptb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [20:0] interval, [41:21] phase, rest zero
   input  logic        req_tuser,   // [0] operation
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] timer_index, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last result of the transaction
);

   state_type            state_ff, state_in;
   logic [SEC_W-1:0]     sec_ff, sec_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [FIELD_W-1:0]   iv_ff, iv_in;
   logic [FIELD_W-1:0]   ph_ff, ph_in;
   logic [PERIOD_W-1:0]  r_ff, r_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   kind_type             resp_kind_ff, resp_kind_in;
   logic [IDX_W-1:0]     resp_idx_ff, resp_idx_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   kind_type             out_kind_ff, out_kind_in;
   logic [IDX_W-1:0]     out_idx_ff, out_idx_in;
   logic                 out_last_ff, out_last_in;

   logic                 req_accept;
   logic                 out_free;
   logic                 iv_ok;
   logic [FIELD_W-1:0]   ph_abs;
   logic [COUNT_W-1:0]   idx_next;
   logic                 more_entries;
   logic                 fire;
   logic                 stall;
   logic [SEC_W:0]       due_sum;
   logic [DIVIDEND_W-1:0] first;
   logic [DIVIDEND_W:0]  next_due;

   // ram and remainder unit hookup
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;
   logic [SEC_W-1:0]     rd_due;
   logic [PERIOD_W-1:0]  rd_period;
   logic                 div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic                 div_done;
   logic [PERIOD_W-1:0]  div_rem;

   ptb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TIMERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptb_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (iv_ff[PERIOD_W-1:0]),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // stored interval is positive when the sign bit is clear and it is nonzero
   assign iv_ok  = !iv_ff[FIELD_W-1] && (iv_ff != '0);
   // magnitude of the phase; the most negative value fits as unsigned
   assign ph_abs = ph_ff[FIELD_W-1] ? (~ph_ff + FIELD_W'(1)) : ph_ff;

   assign rd_due    = ram_rd_data[SEC_W-1:0];
   assign rd_period = ram_rd_data[ENTRY_W-1:SEC_W];

   // scan bookkeeping
   assign idx_next     = {1'b0, idx_ff} + COUNT_W'(1);
   assign more_entries = (idx_next < count_ff);
   assign fire         = (sec_ff >= rd_due);
   // a second due entry must wait until the held one can be sent
   assign stall        = fire && pend_valid_ff && !out_free;
   assign due_sum      = {1'b0, rd_due} + {{(SEC_W - PERIOD_W + 1){1'b0}}, rd_period};

   // first firing: first + (r - first mod iv), wrapped up by one period when negative
   assign first    = {1'b0, sec_ff} + DIVIDEND_W'(1);
   always_comb begin
      next_due = {1'b0, first} + {{(DIVIDEND_W - PERIOD_W + 1){1'b0}}, r_ff}
                 - {{(DIVIDEND_W - PERIOD_W + 1){1'b0}}, div_rem};
      if (r_ff < div_rem) begin
         next_due = next_due + {{(DIVIDEND_W - PERIOD_W + 1){1'b0}}, iv_ff[PERIOD_W-1:0]};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (op_type'(req_tuser) == OP_ADD) begin
                  state_in = ST_ADD_CHECK;
               end else if (count_ff != '0) begin
                  state_in = ST_TICK_EVAL;
               end else begin
                  state_in = ST_TICK_END;
               end
            end
         end
         ST_ADD_CHECK: begin
            if (iv_ok && (count_ff != COUNT_W'(MAX_TIMERS))) begin
               state_in = ST_ADD_PHASE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_ADD_PHASE: begin
            if (div_done) begin
               state_in = ST_ADD_FIRST;
            end
         end
         ST_ADD_FIRST: begin
            if (div_done) begin
               state_in = ST_RESP;
            end
         end
         ST_TICK_EVAL: begin
            if (!stall && !more_entries) begin
               state_in = ST_TICK_END;
            end
         end
         ST_TICK_END: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs per state
   always_comb begin
      req_tready    = 1'b0;
      sec_in        = sec_ff;
      count_in      = count_ff;
      iv_in         = iv_ff;
      ph_in         = ph_ff;
      r_in          = r_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      resp_kind_in  = resp_kind_ff;
      resp_idx_in   = resp_idx_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_idx_in    = out_idx_ff;
      out_last_in   = out_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = {rd_period, rd_due};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      div_start     = 1'b0;
      div_dividend  = {{(DIVIDEND_W - FIELD_W){1'b0}}, ph_abs};

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               iv_in = req_tdata[FIELD_W-1:0];
               ph_in = req_tdata[2*FIELD_W-1:FIELD_W];
               if (op_type'(req_tuser) == OP_TICK) begin
                  if (sec_ff != '1) begin
                     sec_in = sec_ff + SEC_W'(1);
                  end
                  idx_in        = '0;
                  pend_valid_in = 1'b0;
                  ram_rd_en     = (count_ff != '0);
               end
            end
         end
         ST_ADD_CHECK: begin
            resp_idx_in = '0;
            if (!iv_ok) begin
               resp_kind_in = KIND_BAD_INTERVAL;
            end else if (count_ff == COUNT_W'(MAX_TIMERS)) begin
               resp_kind_in = KIND_FULL;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_ADD_PHASE: begin
            if (div_done) begin
               // negative phase with a nonzero remainder wraps upward
               if (ph_ff[FIELD_W-1] && (div_rem != '0)) begin
                  r_in = iv_ff[PERIOD_W-1:0] - div_rem;
               end else begin
                  r_in = div_rem;
               end
               div_start    = 1'b1;
               div_dividend = first;
            end
         end
         ST_ADD_FIRST: begin
            if (div_done) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = count_ff[IDX_W-1:0];
               ram_wr_data = {iv_ff[PERIOD_W-1:0],
                              (next_due[DIVIDEND_W:SEC_W] != '0) ? {SEC_W{1'b1}}
                                                                  : next_due[SEC_W-1:0]};
               resp_kind_in = KIND_ADDED;
               resp_idx_in  = count_ff[IDX_W-1:0];
               count_in     = count_ff + COUNT_W'(1);
            end
         end
         ST_TICK_EVAL: begin
            if (!stall) begin
               if (fire) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff;
                  ram_wr_data = {rd_period, due_sum[SEC_W] ? {SEC_W{1'b1}}
                                                           : due_sum[SEC_W-1:0]};
                  // the held fired entry is not the final one: send it now
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_FIRED;
                     out_idx_in   = pend_idx_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = idx_ff;
               end
               idx_in      = idx_next[IDX_W-1:0];
               ram_rd_en   = more_entries;
               ram_rd_addr = idx_next[IDX_W-1:0];
            end
         end
         ST_TICK_END: begin
            if (pend_valid_ff) begin
               resp_kind_in = KIND_FIRED;
               resp_idx_in  = pend_idx_ff;
            end else begin
               resp_kind_in = KIND_IDLE;
               resp_idx_in  = '0;
            end
            pend_valid_in = 1'b0;
         end
         ST_RESP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = resp_kind_ff;
               out_idx_in   = resp_idx_ff;
               out_last_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sec_ff        <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sec_ff        <= sec_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      iv_ff        <= iv_in;
      ph_ff        <= ph_in;
      r_ff         <= r_in;
      idx_ff       <= idx_in;
      pend_idx_ff  <= pend_idx_in;
      resp_kind_ff <= resp_kind_in;
      resp_idx_ff  <= resp_idx_in;
      out_kind_ff  <= out_kind_in;
      out_idx_ff   <= out_idx_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8 - IDX_W){1'b0}}, out_idx_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* rtl/ptb_checker.sv */
// port-level checker for the periodic timer bank, bound to the top level
// depends on ptb_pkg and periodic_timer_bank_top_defines.svh
`timescale 1ns / 1ps
`include "periodic_timer_bank_top_defines.svh"

module ptb_checker
   import ptb_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a result stalled by the sink holds its contents
   `PTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // one request in work at a time
   `PTB_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

   // every result other than a fired timer ends its transaction
   `PTB_ASSERT_NOW(a_single_last, clock, reset, rsp_tvalid && (rsp_tuser != KIND_FIRED), rsp_tlast, "single result without last")

   // rejected, full and idle results carry index zero
   `PTB_ASSERT_NOW(a_zero_index, clock, reset, rsp_tvalid && ((rsp_tuser == KIND_BAD_INTERVAL) || (rsp_tuser == KIND_FULL) || (rsp_tuser == KIND_IDLE)), rsp_tdata == 8'd0, "nonzero index on status result")

endmodule

bind periodic_timer_bank_top ptb_checker u_ptb_checker (.*);

/* tb/timer_bank_checker.sv */
// result checker of the periodic timer bank: watches both channels,
// keeps its own copy of the timer table and compares every result in order
// depends on ptb_pkg
`timescale 1ns / 1ps

module timer_bank_checker
   import ptb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // [20:0] interval, [41:21] phase, rest zero
   input  logic        req_tuser,   // [0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [3:0] timer_index, rest zero
   input  logic [2:0]  rsp_tuser,   // [2:0] kind
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count,
   output int          added_count,
   output int          rejected_count,
   output int          full_count,
   output int          fired_count,
   output int          quiet_count
);

   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] index;
      logic             last;
   } timer_result_type;

   timer_result_type    awaited_results[$];
   logic [SEC_W-1:0]    seconds_now;
   int unsigned         timers_in_use;
   logic [PERIOD_W-1:0] period_table[MAX_TIMERS];
   logic [SEC_W-1:0]    due_table[MAX_TIMERS];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic await_result(input kind_type kind, input int unsigned index,
                               input logic last);
      timer_result_type item;
      item.kind  = kind;
      item.index = index[IDX_W-1:0];
      item.last  = last;
      awaited_results = {awaited_results, item};
   endtask

   // add: check interval, then table space, then place the first firing
   task automatic book_new_timer(input logic signed [FIELD_W-1:0] interval,
                                 input logic signed [FIELD_W-1:0] phase);
      int                 span;
      int                 offset;
      longint unsigned    step;
      longint unsigned    first;
      longint unsigned    next;
      if (interval <= 0) begin
         await_result(KIND_BAD_INTERVAL, 0, 1'b1);
         rejected_count++;
      end else if (timers_in_use >= MAX_TIMERS) begin
         await_result(KIND_FULL, 0, 1'b1);
         full_count++;
      end else begin
         span   = interval;
         offset = phase;
         offset = offset % span;
         if (offset < 0)
            offset += span;
         step  = span;
         first = seconds_now;
         first = first + 1;
         next  = (first / step) * step + offset;
         if (next < first)
            next += step;
         period_table[timers_in_use] = span[PERIOD_W-1:0];
         due_table[timers_in_use]    = (next > 64'hFFFF_FFFF) ? '1 : next[SEC_W-1:0];
         await_result(KIND_ADDED, timers_in_use, 1'b1);
         timers_in_use++;
         added_count++;
      end
   endtask

   // tick: bump the saturating counter, then fire due entries in index order
   task automatic advance_second();
      logic [MAX_TIMERS-1:0] due_mask;
      int                    final_hit;
      longint unsigned       moved;
      due_mask  = '0;
      final_hit = -1;
      if (seconds_now != '1)
         seconds_now++;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         if (i < timers_in_use && seconds_now >= due_table[i]) begin
            due_mask[i] = 1'b1;
            final_hit   = i;
            moved       = due_table[i];
            moved       = moved + period_table[i];
            due_table[i] = (moved > 64'hFFFF_FFFF) ? '1 : moved[SEC_W-1:0];
         end
      end
      if (final_hit < 0) begin
         await_result(KIND_IDLE, 0, 1'b1);
         quiet_count++;
      end else begin
         for (int i = 0; i < MAX_TIMERS; i++) begin
            if (due_mask[i]) begin
               await_result(KIND_FIRED, i, i == final_hit);
               fired_count++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         awaited_results.delete();
         seconds_now    = '0;
         timers_in_use  = 0;
         fail_count     = 0;
         added_count    = 0;
         rejected_count = 0;
         full_count     = 0;
         fired_count    = 0;
         quiet_count    = 0;
      end else begin
         // prediction first so a same-edge result still meets the older entries
         if (req_tvalid && req_tready) begin
            if (op_type'(req_tuser) == OP_ADD)
               book_new_timer(req_tdata[FIELD_W-1:0], req_tdata[2*FIELD_W-1:FIELD_W]);
            else
               advance_second();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result with none outstanding, kind", rsp_tuser, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("kind", rsp_tuser, want.kind);
               if (rsp_tdata !== {{(8-IDX_W){1'b0}}, want.index})
                  report_mismatch("timer index", rsp_tdata, want.index);
               if (rsp_tlast !== want.last)
                  report_mismatch("last flag", rsp_tlast, want.last);
            end
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

/* tb/periodic_timer_bank_top_tb.sv */
// testbench top of the periodic timer bank: clock, reset, request stimulus,
// result backpressure, watchdog and verdict
// depends on ptb_pkg, periodic_timer_bank_top and timer_bank_checker
`timescale 1ns / 1ps

module periodic_timer_bank_top_tb;
   import ptb_pkg::*;

   localparam int QUIET_LIMIT  = 3000;  // cycles with no transaction at all
   localparam int DRAIN_CYCLES = 100;   // a full add plus a long tick, with margin
   localparam int BLOCKS       = 7;
   localparam int BLOCK_ITEMS  = 50;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;    // [20:0] interval, [41:21] phase, rest zero
   logic        req_tuser;    // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [3:0] timer_index, rest zero
   logic [2:0]  rsp_tuser;    // [2:0] kind
   logic        rsp_tlast;

   int fail_count;
   int pending_count;
   int added_count;
   int rejected_count;
   int full_count;
   int fired_count;
   int quiet_count;

   logic steady_flow;    // when high neither side inserts gaps
   int   stall_left;
   int   quiet_cycles;
   int   items_sent;

   periodic_timer_bank_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   timer_bank_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .added_count    (added_count),
      .rejected_count (rejected_count),
      .full_count     (full_count),
      .fired_count    (fired_count),
      .quiet_count    (quiet_count)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // gap length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // interval mix: mostly small so timers fire often, some huge, some rejected
   function automatic logic signed [FIELD_W-1:0] pick_interval();
      logic signed [FIELD_W-1:0] value;
      int                        roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         value = FIELD_W'($urandom_range(1, 24));
      end else if (roll < 75) begin
         value = FIELD_W'($urandom_range(25, 3000));
      end else if (roll < 88) begin
         value = FIELD_W'($urandom);    // any pattern, sign bit included
      end else begin
         value = FIELD_W'($urandom_range(0, 8));
         value = -value;      // zero or a small negative
      end
      return value;
   endfunction

   // phase mix: full range half of the time, else small around zero
   function automatic logic signed [FIELD_W-1:0] pick_phase();
      logic signed [FIELD_W-1:0] value;
      if ($urandom_range(0, 1) == 0) begin
         value = FIELD_W'($urandom);
      end else begin
         value = FIELD_W'($urandom_range(0, 60));
         value = value - FIELD_W'(30);
      end
      return value;
   endfunction

   // one request transaction; returns at the edge where it was taken.
   // with no gap tvalid simply stays high into the next transaction
   task automatic send_item(input op_type op, input logic signed [FIELD_W-1:0] interval,
                            input logic signed [FIELD_W-1:0] phase);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, phase, interval};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // tick with don't-care payload: the block has to ignore it
   task automatic send_tick();
      logic signed [FIELD_W-1:0] junk_a;
      logic signed [FIELD_W-1:0] junk_b;
      junk_a = FIELD_W'($urandom);
      junk_b = FIELD_W'($urandom);
      send_item(OP_TICK, junk_a, junk_b);
   endtask

   // result side backpressure: random stall bursts unless in steady flow
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: counts cycles in which no transaction happens on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      steady_flow = 1'b0;
      items_sent  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      send_tick();                                        // quiet tick, empty table
      send_item(OP_ADD, 21'sd0, 21'sd0);                  // zero interval rejected
      send_item(OP_ADD, -21'sd1, 21'sd5);                 // negative interval rejected
      send_item(OP_ADD, 21'h100000, 21'h0FFFFF);          // most negative interval
      send_item(OP_ADD, 21'sd1, 21'sd0);                  // fires on every tick
      send_item(OP_ADD, 21'h0FFFFF, 21'h0FFFFF);          // largest interval and phase
      send_item(OP_ADD, 21'h0FFFFF, 21'h100000);          // most negative phase wraps up
      send_item(OP_ADD, 21'sd3, -21'sd1);                 // small negative phase
      send_item(OP_ADD, 21'sd2, 21'h100000);
      send_item(OP_ADD, 21'sd5, 21'sd7);                  // phase above the interval
      repeat (6) send_tick();                             // multi-fire ticks
      send_item(OP_ADD, 21'sd4, 21'h0FFFFF);
      repeat (3) send_tick();

      // random part: adds fill the table along the way, later adds hit the
      // full case; some blocks run with no gaps on either side
      for (int blk = 0; blk < BLOCKS; blk++) begin
         steady_flow <= (blk == 2 || blk == 5);
         for (int k = 0; k < BLOCK_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 18)
               send_item(OP_ADD, pick_interval(), pick_phase());
            else
               send_tick();
         end
      end
      req_tvalid  <= 1'b0;
      steady_flow <= 1'b0;

      // drain: wait until every predicted result has come, then linger
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d request transactions: %0d timers added, %0d bad intervals, %0d full",
               items_sent, added_count, rejected_count, full_count);
      $display("ticks gave %0d timer firings and %0d quiet results", fired_count, quiet_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
